### design/text_cursor_controller_core_macros.svh
// Assertion macros shared by the text cursor controller RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef TEXT_CURSOR_CONTROLLER_CORE_MACROS_SVH
`define TEXT_CURSOR_CONTROLLER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define TCC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Expression must never be true outside reset.
`define TCC_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define TCC_ASSERT(label, prop, msg)
`define TCC_ASSERT_NEVER(label, expr, msg)
`endif

`endif

### design/tcc_pkg.sv
// Shared types and constants of the text cursor controller.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package tcc_pkg;

    localparam int unsigned MAX_COLS = 256;
    localparam int unsigned MAX_ROWS = 128;
    localparam int unsigned CELL_W_MAX = 32;
    localparam int unsigned CELL_H_MAX = 64;
    localparam logic [13:0] PIXEL_MAX = 14'h3FFF;

    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_BACKSPACE = 8'h08;

    // Config register indexes
    typedef enum logic [2:0] {
        REG_ORIGIN_X    = 3'd0,
        REG_ORIGIN_Y    = 3'd1,
        REG_CELL_WIDTH  = 3'd2,
        REG_CELL_HEIGHT = 3'd3,
        REG_TOTAL_COLS  = 3'd4,
        REG_TOTAL_ROWS  = 3'd5,
        REG_BS_ENABLE   = 3'd6
    } reg_idx_t;

    typedef enum logic {
        FUNC_WRITE = 1'b0,
        FUNC_SET   = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        ACT_MOVE    = 2'd0,
        ACT_DRAW    = 2'd1,
        ACT_RESTORE = 2'd2,
        ACT_REJECT  = 2'd3
    } action_t;

    // Effective (clamped) configuration
    typedef struct packed {
        logic [11:0] origin_x;
        logic [11:0] origin_y;
        logic [5:0]  cell_w;   // 0..32
        logic [6:0]  cell_h;   // 0..64
        logic [8:0]  cols;     // 1..256
        logic [7:0]  rows;     // 1..128
        logic        bs_en;
    } cfg_t;

    typedef struct packed {
        func_t      func;
        logic [7:0] char_code;
        logic [7:0] new_row;
        logic [7:0] new_col;
    } item_t;

    typedef struct packed {
        action_t     action;
        logic [13:0] pixel_x;
        logic [13:0] pixel_y;
        logic [7:0]  glyph_code;
        logic [6:0]  cursor_row;
        logic [7:0]  cursor_col;
    } result_t;

endpackage

### design/tcc_cfg_regs.sv
// Configuration register file with range clamping of counts and cell sizes.
// Depends on tcc_pkg.
`timescale 1ns / 1ps

module tcc_cfg_regs
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [11:0]        cfg_data,
    output tcc_pkg::cfg_t      cfg
);

    logic [11:0] origin_x_reg;
    logic [11:0] origin_y_reg;
    logic [5:0]  cell_width_reg;
    logic [6:0]  cell_height_reg;
    logic [8:0]  total_cols_reg;
    logic [7:0]  total_rows_reg;
    logic        bs_enable_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg    <= 12'd0;
            origin_y_reg    <= 12'd0;
            cell_width_reg  <= 6'd8;
            cell_height_reg <= 7'd16;
            total_cols_reg  <= 9'd80;
            total_rows_reg  <= 8'd25;
            bs_enable_reg   <= 1'b1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tcc_pkg::REG_ORIGIN_X:    origin_x_reg    <= cfg_data;
                tcc_pkg::REG_ORIGIN_Y:    origin_y_reg    <= cfg_data;
                tcc_pkg::REG_CELL_WIDTH:  cell_width_reg  <= cfg_data[5:0];
                tcc_pkg::REG_CELL_HEIGHT: cell_height_reg <= cfg_data[6:0];
                tcc_pkg::REG_TOTAL_COLS:  total_cols_reg  <= cfg_data[8:0];
                tcc_pkg::REG_TOTAL_ROWS:  total_rows_reg  <= cfg_data[7:0];
                tcc_pkg::REG_BS_ENABLE:   bs_enable_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Zero counts act as one, large ones saturate; sizes only saturate
    always_comb
    begin
        cfg.origin_x = origin_x_reg;
        cfg.origin_y = origin_y_reg;
        cfg.bs_en    = bs_enable_reg;

        if (cell_width_reg > 6'(tcc_pkg::CELL_W_MAX))
            cfg.cell_w = 6'(tcc_pkg::CELL_W_MAX);
        else
            cfg.cell_w = cell_width_reg;

        if (cell_height_reg > 7'(tcc_pkg::CELL_H_MAX))
            cfg.cell_h = 7'(tcc_pkg::CELL_H_MAX);
        else
            cfg.cell_h = cell_height_reg;

        if (total_cols_reg == 9'd0)
            cfg.cols = 9'd1;
        else if (10'(total_cols_reg) > 10'(tcc_pkg::MAX_COLS))
            cfg.cols = 9'(tcc_pkg::MAX_COLS);
        else
            cfg.cols = total_cols_reg;

        if (total_rows_reg == 8'd0)
            cfg.rows = 8'd1;
        else if (9'(total_rows_reg) > 9'(tcc_pkg::MAX_ROWS))
            cfg.rows = 8'(tcc_pkg::MAX_ROWS);
        else
            cfg.rows = total_rows_reg;
    end

endmodule

### design/tcc_step.sv
// Single-pass cursor step: next cursor and cell pixel origin for one item.
// Depends on tcc_pkg.
`timescale 1ns / 1ps

module tcc_step
(
    input  tcc_pkg::cfg_t    cfg,
    input  tcc_pkg::item_t   item,
    input  logic [6:0]       row_i,
    input  logic [7:0]       col_i,
    output tcc_pkg::result_t res
);

    logic signed [9:0] bc;
    logic signed [8:0] br;
    logic [8:0]        dc;
    logic [7:0]        dr;
    logic [7:0]        nl_row;
    logic [7:0]        px_col;
    logic [6:0]        px_row;
    logic [14:0]       sum_x;
    logic [14:0]       sum_y;
    logic              is_bs;

    // Backspace path; the cursor may sit beyond shrunken counts
    always_comb
    begin
        bc = $signed({2'b00, col_i}) - 10'sd1;
        br = $signed({2'b00, row_i});
        if (bc[9])
        begin
            bc = $signed({1'b0, cfg.cols}) - 10'sd1;
            br = br - 9'sd1;
        end
        if (br[8])
        begin
            br = $signed({1'b0, cfg.rows}) - 9'sd1;
            bc = 10'sd0;
        end
        if (bc >= $signed({1'b0, cfg.cols}))
        begin
            bc = 10'sd0;
            br = br + 9'sd1;
        end
        if (br >= $signed({1'b0, cfg.rows}))
        begin
            br = 9'sd0;
            bc = 10'sd0;
        end
    end

    // Draw path: advance with wrap
    always_comb
    begin
        dc = {1'b0, col_i} + 9'd1;
        dr = {1'b0, row_i};
        if (dc >= cfg.cols)
        begin
            dc = 9'd0;
            dr = dr + 8'd1;
        end
        if (dr >= cfg.rows)
        begin
            dr = 8'd0;
            dc = 9'd0;
        end
    end

    assign nl_row = ({1'b0, row_i} + 8'd1 >= cfg.rows) ? 8'd0 : {1'b0, row_i} + 8'd1;

    // Operands widened first so the products keep all their bits
    assign is_bs  = (item.char_code == tcc_pkg::CHAR_BACKSPACE) && cfg.bs_en;
    assign px_col = is_bs ? bc[7:0] : col_i;
    assign px_row = is_bs ? br[6:0] : row_i;
    assign sum_x  = 15'(cfg.origin_x) + 15'(px_col) * 15'(cfg.cell_w);
    assign sum_y  = 15'(cfg.origin_y) + 15'(px_row) * 15'(cfg.cell_h);

    always_comb
    begin
        res.action     = tcc_pkg::ACT_MOVE;
        res.pixel_x    = 14'd0;
        res.pixel_y    = 14'd0;
        res.glyph_code = 8'd0;
        res.cursor_row = row_i;
        res.cursor_col = col_i;

        if (item.func == tcc_pkg::FUNC_SET)
        begin
            if (item.new_row >= cfg.rows || {1'b0, item.new_col} >= cfg.cols)
                res.action = tcc_pkg::ACT_REJECT;
            else
            begin
                res.cursor_row = item.new_row[6:0];
                res.cursor_col = item.new_col;
            end
        end
        else if (item.char_code == tcc_pkg::CHAR_NEWLINE)
        begin
            res.cursor_row = nl_row[6:0];
            res.cursor_col = 8'd0;
        end
        else
        begin
            res.action  = is_bs ? tcc_pkg::ACT_RESTORE : tcc_pkg::ACT_DRAW;
            res.pixel_x = sum_x[14] ? tcc_pkg::PIXEL_MAX : sum_x[13:0];
            res.pixel_y = sum_y[14] ? tcc_pkg::PIXEL_MAX : sum_y[13:0];
            if (is_bs)
            begin
                res.cursor_row = br[6:0];
                res.cursor_col = bc[7:0];
            end
            else
            begin
                res.glyph_code = item.char_code;
                res.cursor_row = dr[6:0];
                res.cursor_col = dc[7:0];
            end
        end
    end

endmodule

### design/text_cursor_controller_core.sv
// Text cursor controller: top level with input register, step logic and
// result register. Depends on tcc_pkg, tcc_cfg_regs, tcc_step and the macro header.
//
// Usage:
//   Input stream (s_*): one request per item. s_tuser is func (0 write
//   character, 1 set cursor); s_tdata carries char_code, new_row, new_col.
//   Output stream (m_*): exactly one result per request, in order. m_tuser
//   is the action code; m_tdata carries the cell pixel origin, glyph code
//   and the cursor after the request.
//   Config channel (cfg_*): register index and data, always ready, takes
//   effect at once; write only while no request is in flight.
// Pipeline: an accepted request passes two register stages (input register,
//   result register) before it is presented on m_*.
// Throughput: one request per cycle while m_tready is high. The cursor update is a single
//   combinational step between the input register and the result register,
//   so a request following in the next cycle sees the updated cursor.
// Reset: rst_n clears the cursor to row 0, column 0, empties both stages
//   and restores the config registers to their defaults.
// Stall: when m_tready is low the result register holds; the input register
//   takes a request only while empty, then s_tready stays low until the result drains.
`timescale 1ns / 1ps

`include "text_cursor_controller_core_macros.svh"

module text_cursor_controller_core
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] char_code, [15:8] new_row, [23:16] new_col
    input  logic [0:0]  s_tuser,   // [0] func

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [13:0] pixel_x, [27:14] pixel_y, [35:28] glyph_code,
                                   // [42:36] cursor_row_out, [50:43] cursor_col_out, rest 0
    output logic [1:0]  m_tuser,   // [1:0] action

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    tcc_pkg::cfg_t    cfg;
    tcc_pkg::item_t   in_item_reg;
    tcc_pkg::result_t step_res;
    tcc_pkg::result_t res_reg;

    logic       in_valid_reg;
    logic       in_valid_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [6:0] cursor_row_reg;
    logic [7:0] cursor_col_reg;
    logic       s_accept;
    logic       out_load;
    logic       adv;

    tcc_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tcc_step u_step
    (
        .cfg   (cfg),
        .item  (in_item_reg),
        .row_i (cursor_row_reg),
        .col_i (cursor_col_reg),
        .res   (step_res)
    );

    // Handshake: result register loads when empty or draining
    assign out_load = !out_valid_reg || m_tready;
    assign adv      = in_valid_reg && out_load;
    assign s_tready = !in_valid_reg || out_load;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
            in_valid_next = 1'b1;
        else if (adv)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (adv)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            cursor_row_reg <= 7'd0;
            cursor_col_reg <= 8'd0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (adv)
            begin
                cursor_row_reg <= step_res.cursor_row;
                cursor_col_reg <= step_res.cursor_col;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_item_reg.func      <= tcc_pkg::func_t'(s_tuser[0]);
            in_item_reg.char_code <= s_tdata[7:0];
            in_item_reg.new_row   <= s_tdata[15:8];
            in_item_reg.new_col   <= s_tdata[23:16];
        end
        if (adv)
            res_reg <= step_res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res_reg.action;
    assign m_tdata  = {5'd0, res_reg.cursor_col, res_reg.cursor_row, res_reg.glyph_code,
                       res_reg.pixel_y, res_reg.pixel_x};

    // Checks
    `TCC_ASSERT(a_cursor_hold, !$past(adv) |-> ($stable(cursor_row_reg) && $stable(cursor_col_reg)), "cursor moved without a request")
    `TCC_ASSERT(a_result_cursor, adv |=> (res_reg.cursor_row == cursor_row_reg && res_reg.cursor_col == cursor_col_reg), "result cursor differs from state")
    `TCC_ASSERT(a_reject_keeps, (adv && step_res.action == tcc_pkg::ACT_REJECT) |=> ($stable(cursor_row_reg) && $stable(cursor_col_reg)), "rejected set moved cursor")
    `TCC_ASSERT_NEVER(a_glyph_only_draw, m_tvalid && res_reg.action != tcc_pkg::ACT_DRAW && res_reg.glyph_code != 8'd0, "glyph code set on non-draw result")
    `TCC_ASSERT_NEVER(a_no_overwrite, in_valid_reg && !adv && s_accept, "input register overwritten")

endmodule

### sim/tcc_checker.sv
// Checker for the text cursor controller: tracks config writes, predicts the
// result of every accepted request and compares it with the output stream.
// Depends on tcc_pkg.
`timescale 1ns / 1ps

module tcc_checker
    import tcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] char_code, [15:8] new_row, [23:16] new_col
    input  logic [0:0]  s_tuser,   // [0] func

    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,   // [13:0] pixel_x, [27:14] pixel_y, [35:28] glyph_code,
                                   // [42:36] cursor_row_out, [50:43] cursor_col_out, rest 0
    input  logic [1:0]  m_tuser,   // [1:0] action

    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data,

    output int          errors,
    output int          outstanding
);

    // Shadow config, raw register contents
    logic [11:0] org_x;
    logic [11:0] org_y;
    logic [5:0]  cell_w;
    logic [6:0]  cell_h;
    logic [8:0]  col_count;
    logic [7:0]  row_count;
    logic        bs_enabled;

    // Shadow cursor
    logic [6:0]  cur_row;
    logic [7:0]  cur_col;

    result_t     expected_q[$];
    int          fail_count;

    assign errors = fail_count;

    function automatic logic [13:0] cell_origin(logic [11:0] org, int idx, int size, int cap);
        int s;
        int v;
        s = (size > cap) ? cap : size;
        v = int'(org) + idx * s;
        return (v > int'(PIXEL_MAX)) ? PIXEL_MAX : v[13:0];
    endfunction

    // Applies one request to the shadow cursor and returns the expected result.
    function automatic result_t advance_cursor(item_t req);
        result_t r;
        int      cols;
        int      rows;
        int      row;
        int      col;
        cols = (col_count == 0) ? 1 : ((col_count > MAX_COLS) ? MAX_COLS : int'(col_count));
        rows = (row_count == 0) ? 1 : ((row_count > MAX_ROWS) ? MAX_ROWS : int'(row_count));
        row  = cur_row;
        col  = cur_col;
        r    = '0;
        r.action = ACT_MOVE;
        if (req.func == FUNC_SET) begin
            if (int'(req.new_row) >= rows || int'(req.new_col) >= cols)
                r.action = ACT_REJECT;
            else begin
                row = req.new_row;
                col = req.new_col;
            end
        end
        else if (req.char_code == CHAR_NEWLINE) begin
            row++;
            if (row >= rows) row = 0;
            col = 0;
        end
        else if (req.char_code == CHAR_BACKSPACE && bs_enabled) begin
            col--;
            if (col < 0) begin col = cols - 1; row--; end
            if (row < 0) begin row = rows - 1; col = 0; end
            if (col >= cols) begin col = 0; row++; end
            if (row >= rows) begin row = 0; col = 0; end
            r.action  = ACT_RESTORE;
            r.pixel_x = cell_origin(org_x, col, cell_w, CELL_W_MAX);
            r.pixel_y = cell_origin(org_y, row, cell_h, CELL_H_MAX);
        end
        else begin
            r.action     = ACT_DRAW;
            r.glyph_code = req.char_code;
            r.pixel_x    = cell_origin(org_x, col, cell_w, CELL_W_MAX);
            r.pixel_y    = cell_origin(org_y, row, cell_h, CELL_H_MAX);
            col++;
            if (col >= cols) begin col = 0; row++; end
            if (row >= rows) begin row = 0; col = 0; end
        end
        cur_row = row[6:0];
        cur_col = col[7:0];
        r.cursor_row = cur_row;
        r.cursor_col = cur_col;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t ns  mismatch: %s got %0d want %0d", $time, what, got, want);
        fail_count++;
    endtask

    task automatic check_result();
        result_t want;
        if (expected_q.size() == 0) begin
            report_mismatch("result with no request pending, action", m_tuser, -1);
            return;
        end
        want = expected_q.pop_front();
        if (m_tuser != want.action)
            report_mismatch("action", m_tuser, want.action);
        if (m_tdata[13:0] != want.pixel_x)
            report_mismatch("pixel_x", m_tdata[13:0], want.pixel_x);
        if (m_tdata[27:14] != want.pixel_y)
            report_mismatch("pixel_y", m_tdata[27:14], want.pixel_y);
        if (m_tdata[35:28] != want.glyph_code)
            report_mismatch("glyph_code", m_tdata[35:28], want.glyph_code);
        if (m_tdata[42:36] != want.cursor_row)
            report_mismatch("cursor_row_out", m_tdata[42:36], want.cursor_row);
        if (m_tdata[50:43] != want.cursor_col)
            report_mismatch("cursor_col_out", m_tdata[50:43], want.cursor_col);
        if (m_tdata[55:51] != '0)
            report_mismatch("tdata padding", m_tdata[55:51], 0);
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            org_x       = '0;
            org_y       = '0;
            cell_w      = 6'd8;
            cell_h      = 7'd16;
            col_count   = 9'd80;
            row_count   = 8'd25;
            bs_enabled  = 1'b1;
            cur_row     = '0;
            cur_col     = '0;
            fail_count  = 0;
            expected_q.delete();
            outstanding <= 0;
        end
        else begin
            if (m_tvalid && m_tready)
                check_result();
            if (s_tvalid && s_tready)
                expected_q.push_back(advance_cursor('{func:      func_t'(s_tuser[0]),
                                                       char_code: s_tdata[7:0],
                                                       new_row:   s_tdata[15:8],
                                                       new_col:   s_tdata[23:16]}));
            if (cfg_valid && cfg_ready) begin
                case (reg_idx_t'(cfg_index))
                    REG_ORIGIN_X:    org_x      = cfg_data;
                    REG_ORIGIN_Y:    org_y      = cfg_data;
                    REG_CELL_WIDTH:  cell_w     = cfg_data[5:0];
                    REG_CELL_HEIGHT: cell_h     = cfg_data[6:0];
                    REG_TOTAL_COLS:  col_count  = cfg_data[8:0];
                    REG_TOTAL_ROWS:  row_count  = cfg_data[7:0];
                    REG_BS_ENABLE:   bs_enabled = cfg_data[0];
                    default: ;
                endcase
            end
            outstanding <= expected_q.size();
        end
    end

endmodule

### sim/tb_top.sv
// Top of the text cursor controller testbench: clock, reset, request and
// config stimulus, output back-pressure and the verdict. Depends on tcc_pkg,
// tcc_checker and the text_cursor_controller_core RTL.
`timescale 1ns / 1ps

module tb_top;
    import tcc_pkg::*;

    // Cycles without any handshake before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;

    logic        clk;
    logic        rst_n;

    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;    // [7:0] char_code, [15:8] new_row, [23:16] new_col
    logic [0:0]  s_tuser;    // [0] func

    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;    // [13:0] pixel_x, [27:14] pixel_y, [35:28] glyph_code,
                             // [42:36] cursor_row_out, [50:43] cursor_col_out, rest 0
    logic [1:0]  m_tuser;    // [1:0] action

    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [11:0] cfg_data;

    int          errors;
    int          outstanding;

    // Random idling on both streams is on while this is set.
    logic        idle_on = 1'b1;
    int          ready_hold = 0;
    int          idle_cycles = 0;

    // Effective grid size, used only to steer cursor sets into range.
    int          n_cols = 80;
    int          n_rows = 25;

    text_cursor_controller_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tcc_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .outstanding (outstanding)
    );

    // 4 ns clock
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Output back-pressure: while idle_on is set, m_tready drops in random bursts.
    initial m_tready = 1'b0;
    always @(posedge clk)
    begin
        if (ready_hold != 0)
        begin
            m_tready   <= 1'b0;
            ready_hold <= ready_hold - 1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            m_tready   <= 1'b0;
            ready_hold <= $urandom_range(0, 2);
        end
        else
            m_tready <= 1'b1;
    end

    // Watchdog: any handshake on any channel restarts the count.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[text_cursor_controller_core] ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // One request on the input stream. Valid stays high into the next request
    // unless a gap is drawn, so back-to-back requests go out every cycle while s_tready is high.
    task automatic send_request(func_t f, logic [7:0] code, logic [7:0] row, logic [7:0] col);
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {col, row, code};
        do
            @(posedge clk);
        while (!s_tready);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    // Stop sending and hold off until every pending request has its result.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // Config write; valid is left high so a following write can chain.
    task automatic write_reg(reg_idx_t idx, logic [11:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // Write all seven registers. Only call with the block drained.
    task automatic apply_config(logic [11:0] ox, logic [11:0] oy, logic [11:0] cw,
                                logic [11:0] chh, logic [11:0] cols, logic [11:0] rows,
                                logic [11:0] bs);
        int c;
        int r;
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_CELL_WIDTH, cw);
        write_reg(REG_CELL_HEIGHT, chh);
        write_reg(REG_TOTAL_COLS, cols);
        write_reg(REG_TOTAL_ROWS, rows);
        write_reg(REG_BS_ENABLE, bs);
        cfg_valid <= 1'b0;
        c = cols[8:0];
        r = rows[7:0];
        if (c == 0) c = 1;
        if (c > MAX_COLS) c = MAX_COLS;
        if (r == 0) r = 1;
        if (r > MAX_ROWS) r = MAX_ROWS;
        n_cols = c;
        n_rows = r;
    endtask

    // Park the cursor at row 20, col 70, then shrink the grid to 10x10 under it
    // and send one byte, so the wrap compares see a cursor beyond the counts.
    task automatic shrink_under_cursor(logic [7:0] code);
        wait_drained();
        apply_config(12'd0, 12'd0, 12'd8, 12'd16, 12'd80, 12'd25, 12'd1);
        send_request(FUNC_SET, 8'h00, 8'd20, 8'd70);
        wait_drained();
        apply_config(12'd100, 12'd50, 12'd8, 12'd16, 12'd10, 12'd10, 12'd1);
        send_request(FUNC_WRITE, code, $urandom, $urandom);
    endtask

    // Random settings: small grids mostly so wraps are frequent, with the
    // count and cell size extremes, and now and then junk above each field narrower than 12 bits.
    task automatic random_config();
        logic [11:0] ox;
        logic [11:0] oy;
        logic [11:0] cw;
        logic [11:0] chh;
        logic [11:0] cols;
        logic [11:0] rows;
        logic [11:0] bs;
        case ($urandom_range(0, 3))
            0:       ox = 12'd0;
            1:       ox = 12'hFFF;
            default: ox = $urandom_range(0, 4095);
        endcase
        case ($urandom_range(0, 3))
            0:       oy = 12'd0;
            1:       oy = 12'hFFF;
            default: oy = $urandom_range(0, 4095);
        endcase
        cw  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 32);
        chh = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 64);
        case ($urandom_range(0, 7))
            0:       cols = 12'd0;
            1:       cols = 12'd256;
            2:       cols = $urandom_range(257, 511);
            default: cols = $urandom_range(1, 16);
        endcase
        case ($urandom_range(0, 7))
            0:       rows = 12'd0;
            1:       rows = 12'd128;
            2:       rows = $urandom_range(129, 255);
            default: rows = $urandom_range(1, 12);
        endcase
        bs = ($urandom_range(0, 3) != 0) ? 12'd1 : 12'd0;
        if ($urandom_range(0, 3) == 0)
        begin
            // bits past each register's width must be dropped
            cw[11:6]   = $urandom_range(0, 63);
            chh[11:7]  = $urandom_range(0, 31);
            cols[11:9] = $urandom_range(0, 7);
            rows[11:8] = $urandom_range(0, 15);
            bs[11:1]   = $urandom_range(0, 2047);
        end
        apply_config(ox, oy, cw, chh, cols, rows, bs);
    endtask

    // Mix: newlines, backspaces, cursor sets (mostly in range) and glyph bytes.
    // Unused tdata fields carry random bits so every bit toggles.
    task automatic random_request();
        int         pick;
        logic [7:0] code;
        logic [7:0] row;
        logic [7:0] col;
        code = $urandom;
        row  = $urandom;
        col  = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 12)
            send_request(FUNC_WRITE, CHAR_NEWLINE, row, col);
        else if (pick < 26)
            send_request(FUNC_WRITE, CHAR_BACKSPACE, row, col);
        else if (pick < 42)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                row = $urandom_range(0, n_rows - 1);
                col = $urandom_range(0, n_cols - 1);
            end
            send_request(FUNC_SET, code, row, col);
        end
        else
            send_request(FUNC_WRITE, code, row, col);
    endtask

    initial
    begin
        int phase;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_ORIGIN_X;
        cfg_data  = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: 80x25 grid of 8x16 cells, backspace on.
        // Backspace at home goes to the last row, column 0.
        send_request(FUNC_WRITE, CHAR_BACKSPACE, 8'h00, 8'h00);
        send_request(FUNC_WRITE, 8'h41, 8'h00, 8'h00);
        // newline on the last row wraps to the top
        send_request(FUNC_WRITE, CHAR_NEWLINE, 8'h00, 8'h00);
        send_request(FUNC_WRITE, 8'h00, 8'hFF, 8'hFF);
        send_request(FUNC_WRITE, 8'hFF, 8'h00, 8'h00);
        // draw in the last cell wraps to home
        send_request(FUNC_SET, 8'h00, 8'd24, 8'd79);
        send_request(FUNC_WRITE, 8'h5A, 8'h00, 8'h00);
        // rejected sets: row at count, column at count, both maxed
        send_request(FUNC_SET, 8'h00, 8'd25, 8'd0);
        send_request(FUNC_SET, 8'h00, 8'd0, 8'd80);
        send_request(FUNC_SET, 8'hFF, 8'hFF, 8'hFF);
        // backspace at column 0 goes to the end of the previous row
        send_request(FUNC_SET, 8'h00, 8'd3, 8'd0);
        send_request(FUNC_WRITE, CHAR_BACKSPACE, 8'h00, 8'h00);

        // Largest origin, oversize cells and counts clamp, backspace off.
        wait_drained();
        apply_config(12'hFFF, 12'hFFF, 12'd63, 12'd127, 12'd511, 12'd255, 12'd0);
        send_request(FUNC_SET, 8'h00, 8'd127, 8'd255);
        send_request(FUNC_WRITE, 8'h71, 8'h00, 8'h00);
        send_request(FUNC_SET, 8'h00, 8'd127, 8'd0);
        // with backspace off, 0x08 is just another glyph
        send_request(FUNC_WRITE, CHAR_BACKSPACE, 8'h00, 8'h00);
        send_request(FUNC_WRITE, CHAR_NEWLINE, 8'h00, 8'h00);

        // Zero counts act as 1x1, zero cell size keeps every cell at the origin.
        wait_drained();
        apply_config(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd1);
        send_request(FUNC_WRITE, 8'h78, 8'h00, 8'h00);
        send_request(FUNC_WRITE, CHAR_BACKSPACE, 8'h00, 8'h00);
        send_request(FUNC_WRITE, CHAR_NEWLINE, 8'h00, 8'h00);
        send_request(FUNC_SET, 8'h00, 8'd1, 8'd0);
        send_request(FUNC_SET, 8'h00, 8'd0, 8'd1);
        send_request(FUNC_SET, 8'h00, 8'd0, 8'd0);

        // Cursor left outside a grid that shrank under it.
        shrink_under_cursor(8'h23);
        shrink_under_cursor(CHAR_NEWLINE);
        shrink_under_cursor(CHAR_BACKSPACE);

        // Random phases. Each starts drained, with new settings; the last one
        // runs without idling on either stream.
        for (phase = 0; phase < 12; phase++)
        begin
            wait_drained();
            random_config();
            idle_on <= (phase == 11) ? 1'b0 : ($urandom_range(0, 3) != 0);
            repeat (108) random_request();
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("[text_cursor_controller_core] OK");
        else
            $display("[text_cursor_controller_core] ERROR");
        $finish;
    end

endmodule

### filelist.f
+incdir+design
design/tcc_pkg.sv
design/tcc_cfg_regs.sv
design/tcc_step.sv
design/text_cursor_controller_core.sv
sim/tcc_checker.sv
sim/tb_top.sv
